// File: hdl/dss_pkg.sv
// Shared types and constants for the duplicate sighting suppressor.
package dss_pkg;

  localparam int ENTRIES = 24;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W  = 48;
  localparam int ROLE_W  = 2;
  localparam int TIME_W  = 32;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(15000);

  // operation codes
  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ROLE_W-1:0] role;
    logic [TIME_W-1:0] now;
  } query_t;

  // partial search result handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  match_idx;
    logic [TIME_W-1:0] match_age;
    logic [TIME_W-1:0] best_age;
    logic [IDX_W-1:0]  best_idx;
  } carry_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic             clear;
    logic             refresh;
    logic             replace;
    logic [IDX_W-1:0] idx;
  } wcmd_t;

endpackage

// File: hdl/dss_in_if.sv
// Input channel interface: check or clear words.
interface dss_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [dss_pkg::ADDR_W-1:0]   station_address;
  logic [dss_pkg::ROLE_W-1:0]   address_role;
  logic [dss_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, func, station_address, address_role, now_ms,
                  input ready);
  modport sink   (input valid, func, station_address, address_role, now_ms,
                  output ready);
endinterface

// File: hdl/dss_out_if.sv
// Result channel interface: one suppressed flag per word.
interface dss_out_if;
  logic valid;
  logic ready;
  logic suppressed;

  modport source (output valid, suppressed, input ready);
  modport sink   (input valid, suppressed, output ready);
endinterface

// File: hdl/duplicate_sighting_suppressor_unit.sv
// Top level: sighting table as a chain of cells, control and APB register.
// The search carry steps one cell per cycle from cell 0 to the last cell; a
// check word's result then passes state ST_DONE into the output register. A
// clear word passes ST_CLEAR and ST_DONE into the output register. One word is
// in flight at a time: a new word is taken only once the last result is registered.
// Reset (rst_n low, synchronous) empties the table, sets the window to 15000.
module duplicate_sighting_suppressor_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  dss_in_if.sink                      in_chan,
  dss_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dss_pkg::CFG_AW-1:0]  paddr,
  input  logic [dss_pkg::CFG_DW-1:0]  pwdata,
  output logic [dss_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  dss_pkg::state_t            state_r, state_nxt;
  dss_pkg::query_t            query_r;
  logic                       start_r;
  logic                       res_r, res_nxt;
  logic                       out_valid_r;
  logic                       out_supp_r;
  logic [dss_pkg::TIME_W-1:0] window_r;

  dss_pkg::carry_t            carry_init;
  dss_pkg::carry_t            chain [dss_pkg::ENTRIES];
  dss_pkg::carry_t            tail;
  dss_pkg::wcmd_t             wcmd;
  logic                       in_acc;
  logic                       out_free;
  logic                       supp;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= dss_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == dss_pkg::REG_WINDOW)) begin
      window_r <= pwdata;
    end
  end

  // ---------------- input side ----------------
  assign in_chan.ready = (state_r == dss_pkg::ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  // query held steady for the whole pass and the table write after it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      query_r.addr <= in_chan.station_address;
      query_r.role <= in_chan.address_role;
      query_r.now  <= in_chan.now_ms;
    end
  end

  // one-cycle pulse that launches the carry into cell 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
    end else begin
      start_r <= in_acc && (in_chan.func == dss_pkg::FUNC_CHECK);
    end
  end

  always_comb begin
    carry_init       = '0;
    carry_init.valid = start_r;
  end

  // ---------------- cell chain ----------------
  // carry walks from cell 0 upward, so the lowest matching index sticks
  for (genvar k = 0; k < dss_pkg::ENTRIES; k++) begin : g_cell
    dss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (dss_pkg::IDX_W'(k)),
      .query     (query_r),
      .wcmd      (wcmd),
      .carry_in  ((k == 0) ? carry_init : chain[(k == 0) ? 0 : k - 1]),
      .carry_out (chain[k])
    );
  end

  assign tail = chain[dss_pkg::ENTRIES-1];

  // ---------------- decision at chain end ----------------
  assign supp = tail.found && (tail.match_age < window_r);

  always_comb begin
    wcmd.clear   = (state_r == dss_pkg::ST_CLEAR);
    wcmd.refresh = tail.valid && tail.found && !supp;
    wcmd.replace = tail.valid && !tail.found;
    wcmd.idx     = tail.found ? tail.match_idx : tail.best_idx;
  end

  // ---------------- control ----------------
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    case (state_r)
      dss_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_chan.func == dss_pkg::FUNC_CLEAR) ? dss_pkg::ST_CLEAR
                                                           : dss_pkg::ST_SCAN;
        end
      end
      dss_pkg::ST_SCAN: begin
        if (tail.valid) begin
          res_nxt   = supp;
          state_nxt = dss_pkg::ST_DONE;
        end
      end
      dss_pkg::ST_CLEAR: begin
        res_nxt   = 1'b0;
        state_nxt = dss_pkg::ST_DONE;
      end
      dss_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = dss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == dss_pkg::ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
      out_supp_r  <= res_r;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.suppressed = out_supp_r;

endmodule

// File: hdl/dss_cell.sv
// One table entry plus one stage of the match / oldest-entry search chain.
module dss_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dss_pkg::IDX_W-1:0]  cell_idx,
  input  dss_pkg::query_t            query,
  input  dss_pkg::wcmd_t             wcmd,
  input  dss_pkg::carry_t            carry_in,
  output dss_pkg::carry_t            carry_out
);

  logic [dss_pkg::ADDR_W-1:0] addr_r;
  logic [dss_pkg::ROLE_W-1:0] role_r;
  logic [dss_pkg::TIME_W-1:0] seen_r;
  logic                       valid_r;

  logic [dss_pkg::TIME_W-1:0] age;
  logic                       hit;
  dss_pkg::carry_t            carry_nxt;
  dss_pkg::carry_t            carry_r;

  // unused entries count as oldest possible
  assign age = valid_r ? (query.now - seen_r) : '1;
  assign hit = valid_r && (addr_r == query.addr) && (role_r == query.role);

  always_comb begin
    carry_nxt       = carry_in;
    carry_nxt.found = carry_in.found | hit;
    if (!carry_in.found && hit) begin
      carry_nxt.match_idx = cell_idx;
      carry_nxt.match_age = age;
    end
    // ties go to the higher index
    if (age >= carry_in.best_age) begin
      carry_nxt.best_age = age;
      carry_nxt.best_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign carry_out = carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wcmd.clear) begin
      valid_r <= 1'b0;
    end else if (wcmd.idx == cell_idx) begin
      if (wcmd.replace) begin
        valid_r <= 1'b1;
        addr_r  <= query.addr;
        role_r  <= query.role;
        seen_r  <= query.now;
      end else if (wcmd.refresh) begin
        seen_r  <= query.now;
      end
    end
  end

endmodule

// File: hdl/dss_checker.sv
// Port-level checker for the suppressor, bound to the top level.
module dss_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic out_valid,
  input logic out_ready,
  input logic out_suppressed
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_suppressed))
    else $error("stalled result word changed");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // a clear word's result, not suppressed, follows via ST_CLEAR and ST_DONE when the output is empty
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_func == dss_pkg::FUNC_CLEAR) && !out_valid
      |-> ##3 out_valid && !out_suppressed)
    else $error("clear word result wrong or late");

  // no result appears the cycle after an accept into an empty output
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid |=> !out_valid)
    else $error("result word too early");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind duplicate_sighting_suppressor_unit dss_checker u_dss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_func        (in_chan.func),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_suppressed (out_chan.suppressed)
);
